// File: rtl/eqc_pkg.sv
// Shared types, constants and fixed-point helpers for the Euler/quaternion converter.
// No dependencies; used by eqc_top-level logic and the port checker.
package eqc_pkg;

  localparam logic OP_E2Q = 1'b0;  // Euler angles to quaternion
  localparam logic OP_Q2E = 1'b1;  // quaternion to Euler angles

  localparam int CORDIC_STAGES = 24;
  localparam int SQRT_STEPS    = 31;

  localparam int LANE_W = 42;
  localparam int ANG_W  = 36;

  // Stage positions along the pipeline.
  localparam int ST_PROD    = 1;
  localparam int ST_SUM     = 2;
  localparam int ST_RAD     = 3;
  localparam int ST_SQRT    = 4;
  localparam int ST_VEC     = ST_SQRT + SQRT_STEPS;
  localparam int ST_CORD    = ST_VEC + 1;
  localparam int ST_MUL     = ST_CORD + CORDIC_STAGES;
  localparam int ST_FIN     = ST_MUL + 1;
  localparam int NUM_STAGES = ST_FIN + 1;

  localparam logic signed [ANG_W-1:0]  PI_W      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0]  HALF_PI_W = 36'sd1686629713;
  localparam logic signed [LANE_W-1:0] ONE_W     = 42'sd1073741824;
  localparam logic signed [LANE_W-1:0] GAIN_INV  = 42'sd652032874;

  typedef struct packed {
    logic                          op;
    logic [63:0]                   stamp;
    logic [30:0]                   roll;
    logic [30:0]                   pitch;
    logic [30:0]                   yaw;
    logic [31:0]                   qw;
    logic [31:0]                   qx;
    logic [31:0]                   qy;
    logic [31:0]                   qz;
    logic [8:0][ANG_W-1:0]         pr;
    logic [2:0][LANE_W-1:0]        lx;
    logic [2:0][LANE_W-1:0]        ly;
    logic [2:0][ANG_W-1:0]         lz;
    logic [2:0]                    lflag;
    logic [3:0][ANG_W-1:0]         m;
    logic [61:0]                   sq_n;
    logic [61:0]                   sq_r;
    logic                          clamp;
    logic [31:0]                   rw;
    logic [31:0]                   rx;
    logic [31:0]                   ry;
    logic [31:0]                   rz;
    logic [30:0]                   rr;
    logic [30:0]                   rp;
    logic [30:0]                   ryaw;
  } stage_t;

  // Arctangent of 2^-i in Q.30, truncated.
  function automatic logic [29:0] atan_entry(input int i);
    logic [29:0] v;
    case (i)
      0: v = 30'd843314856;   1: v = 30'd497837829;   2: v = 30'd263043836;
      3: v = 30'd133525158;   4: v = 30'd67021686;    5: v = 30'd33543515;
      6: v = 30'd16775850;    7: v = 30'd8388437;     8: v = 30'd4194282;
      9: v = 30'd2097149;     10: v = 30'd1048575;    11: v = 30'd524287;
      12: v = 30'd262143;     13: v = 30'd131071;     14: v = 30'd65535;
      15: v = 30'd32767;      16: v = 30'd16383;      17: v = 30'd8191;
      18: v = 30'd4095;       19: v = 30'd2047;       20: v = 30'd1023;
      21: v = 30'd511;        22: v = 30'd255;        23: v = 30'd127;
      24: v = 30'd63;         25: v = 30'd31;         26: v = 30'd15;
      27: v = 30'd8;          28: v = 30'd4;          29: v = 30'd2;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Q.30 product, rounded to nearest with halves upwards.
  function automatic logic signed [ANG_W-1:0] mulw(input logic signed [33:0] a,
                                                   input logic signed [33:0] b);
    logic signed [67:0] p;
    begin
      p = a * b;
      p = p + 68'sd536870912;
      return p[65:30];
    end
  endfunction

  function automatic logic signed [LANE_W-1:0] x42(input logic [ANG_W-1:0] v);
    return {{(LANE_W-ANG_W){v[ANG_W-1]}}, v};
  endfunction

  function automatic logic signed [33:0] q34(input logic [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    begin
      if (v > 38'sd2147483647) r = 32'sh7fffffff;
      else if (v < -38'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

  // Q.30 angle to Q3.28, rounded and saturated.
  function automatic logic signed [30:0] to_angle(input logic signed [ANG_W-1:0] z);
    logic signed [ANG_W-1:0] t;
    logic signed [30:0]      r;
    begin
      t = (z + 36'sd2) >>> 2;
      if (t > 36'sd1073741823) r = 31'sh3fffffff;
      else if (t < -36'sd1073741824) r = 31'sh40000000;
      else r = t[30:0];
      return r;
    end
  endfunction

endpackage

// File: rtl/euler_quaternion_convert_top.sv
// Top level of the Euler/quaternion converter: one pipeline of eqc_pkg::NUM_STAGES stages.
// Depends on eqc_pkg for the stage record, constants and arithmetic helpers.
//
// Usage: an input beat carries opcode_i, stamp_i, the three angles and the four quaternion
// parts on a valid/ready channel; one result beat leaves on the output channel for each
// input beat, in order. Opcode 0 turns roll, pitch and yaw (Q3.28) into a quaternion
// (Q2.30); opcode 1 turns a quaternion into angles, flagging a saturated asin argument.
// The representation that is not computed, and the timestamp, are copied through.
// The throughput is one beat per cycle while out_ready_i is not held low. The depth is
// set by the 31 one-bit square root steps and the 24 shared CORDIC iterations that run
// after them.
// Each stage holds its own valid bit and advances when it is empty or the stage after it
// advances, so a stalled receiver holds the last result while bubbles further up are
// squeezed out and new beats are still taken until the pipeline is full.
// Reset empties the pipeline; no result is presented until a beat has been accepted.
module euler_quaternion_convert_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic signed [63:0] stamp_i,
  input  logic signed [30:0] roll_angle_i,
  input  logic signed [30:0] pitch_angle_i,
  input  logic signed [30:0] yaw_angle_i,
  input  logic signed [31:0] quat_w_i,
  input  logic signed [31:0] quat_x_i,
  input  logic signed [31:0] quat_y_i,
  input  logic signed [31:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] stamp_out_o,
  output logic signed [30:0] out_roll_o,
  output logic signed [30:0] out_pitch_o,
  output logic signed [30:0] out_yaw_o,
  output logic signed [31:0] out_w_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               asin_clamped_o
);

  localparam int NS = eqc_pkg::NUM_STAGES;

  eqc_pkg::stage_t         pipe_q [NS];
  eqc_pkg::stage_t         pipe_d [NS];
  logic [NS-1:0]           vld_q;
  logic [NS:0]             adv;

  function automatic eqc_pkg::stage_t step(input int k, input eqc_pkg::stage_t s);
    eqc_pkg::stage_t                   r;
    logic [2:0][30:0]                  ain;
    logic signed [eqc_pkg::ANG_W-1:0]  h;
    logic signed [eqc_pkg::ANG_W-1:0]  ss;
    logic signed [eqc_pkg::ANG_W-1:0]  atn;
    logic signed [eqc_pkg::LANE_W-1:0] sv;
    logic signed [eqc_pkg::LANE_W-1:0] dx;
    logic signed [eqc_pkg::LANE_W-1:0] dy;
    logic [61:0]                       bitv;
    logic [61:0]                       trial;
    logic [30:0]                       rad;
    logic [2:0][33:0]                  cv;
    logic [2:0][33:0]                  sn;
    logic signed [37:0]                acc;
    logic                              d;
    int                                it;
    begin
      r   = s;
      ain = {s.yaw, s.pitch, s.roll};
      if (k == eqc_pkg::ST_PROD) begin
        if (s.op == eqc_pkg::OP_E2Q) begin
          // Half angle in Q.30, folded into [-pi/2, pi/2].
          for (int l = 0; l < 3; l++) begin
            h = {{4{ain[l][30]}}, ain[l], 1'b0};
            r.lflag[l] = 1'b0;
            if (h > eqc_pkg::HALF_PI_W) begin
              h = h - eqc_pkg::PI_W;
              r.lflag[l] = 1'b1;
            end else if (h < -eqc_pkg::HALF_PI_W) begin
              h = h + eqc_pkg::PI_W;
              r.lflag[l] = 1'b1;
            end
            r.lz[l] = h;
            r.lx[l] = eqc_pkg::GAIN_INV;
            r.ly[l] = '0;
          end
        end else begin
          r.pr[0] = eqc_pkg::mulw(eqc_pkg::q34(s.qw), eqc_pkg::q34(s.qx));
          r.pr[1] = eqc_pkg::mulw(eqc_pkg::q34(s.qy), eqc_pkg::q34(s.qz));
          r.pr[2] = eqc_pkg::mulw(eqc_pkg::q34(s.qx), eqc_pkg::q34(s.qx));
          r.pr[3] = eqc_pkg::mulw(eqc_pkg::q34(s.qy), eqc_pkg::q34(s.qy));
          r.pr[4] = eqc_pkg::mulw(eqc_pkg::q34(s.qw), eqc_pkg::q34(s.qz));
          r.pr[5] = eqc_pkg::mulw(eqc_pkg::q34(s.qx), eqc_pkg::q34(s.qy));
          r.pr[6] = eqc_pkg::mulw(eqc_pkg::q34(s.qz), eqc_pkg::q34(s.qz));
          r.pr[7] = eqc_pkg::mulw(eqc_pkg::q34(s.qw), eqc_pkg::q34(s.qy));
          r.pr[8] = eqc_pkg::mulw(eqc_pkg::q34(s.qz), eqc_pkg::q34(s.qx));
        end
      end else if (k == eqc_pkg::ST_SUM) begin
        if (s.op == eqc_pkg::OP_Q2E) begin
          r.ly[0] = (eqc_pkg::x42(s.pr[0]) + eqc_pkg::x42(s.pr[1])) <<< 1;
          r.lx[0] = eqc_pkg::ONE_W - ((eqc_pkg::x42(s.pr[2]) + eqc_pkg::x42(s.pr[3])) <<< 1);
          r.ly[2] = (eqc_pkg::x42(s.pr[4]) + eqc_pkg::x42(s.pr[5])) <<< 1;
          r.lx[2] = eqc_pkg::ONE_W - ((eqc_pkg::x42(s.pr[3]) + eqc_pkg::x42(s.pr[6])) <<< 1);
          sv = (eqc_pkg::x42(s.pr[7]) - eqc_pkg::x42(s.pr[8])) <<< 1;
          if (sv > eqc_pkg::ONE_W) begin
            sv      = eqc_pkg::ONE_W;
            r.clamp = 1'b1;
          end else if (sv < -eqc_pkg::ONE_W) begin
            sv      = -eqc_pkg::ONE_W;
            r.clamp = 1'b1;
          end
          r.ly[1] = sv;
        end
      end else if (k == eqc_pkg::ST_RAD) begin
        // Radicand of the asin cosine, 1 - s*s, moved up to Q.60.
        ss     = eqc_pkg::mulw(s.ly[1][33:0], s.ly[1][33:0]);
        h      = 36'sd1073741824 - ss;
        rad    = h[30:0];
        r.sq_n = {1'b0, rad, 30'd0};
        r.sq_r = '0;
      end else if (k >= eqc_pkg::ST_SQRT && k < eqc_pkg::ST_VEC) begin
        it    = eqc_pkg::SQRT_STEPS - 1 - (k - eqc_pkg::ST_SQRT);
        bitv  = 62'd1 << (2 * it);
        trial = s.sq_r + bitv;
        if (s.sq_n >= trial) begin
          r.sq_n = s.sq_n - trial;
          r.sq_r = (s.sq_r >> 1) + bitv;
        end else begin
          r.sq_r = s.sq_r >> 1;
        end
      end else if (k == eqc_pkg::ST_VEC) begin
        if (s.op == eqc_pkg::OP_Q2E) begin
          r.lx[1] = {11'd0, s.sq_r[30:0]};
          for (int l = 0; l < 3; l++) begin
            r.lflag[l] = (r.lx[l] == '0) && (r.ly[l] == '0);
            r.lz[l]    = '0;
            if (r.lx[l][eqc_pkg::LANE_W-1]) begin
              r.lz[l] = r.ly[l][eqc_pkg::LANE_W-1] ? -eqc_pkg::PI_W : eqc_pkg::PI_W;
              r.lx[l] = -$signed(r.lx[l]);
              r.ly[l] = -$signed(r.ly[l]);
            end
          end
        end
      end else if (k >= eqc_pkg::ST_CORD && k < eqc_pkg::ST_MUL) begin
        // One CORDIC iteration on all three lanes: rotation for opcode 0, vectoring for 1.
        it  = k - eqc_pkg::ST_CORD;
        atn = {6'd0, eqc_pkg::atan_entry(it)};
        for (int l = 0; l < 3; l++) begin
          dx = $signed(s.ly[l]) >>> it;
          dy = $signed(s.lx[l]) >>> it;
          d  = (s.op == eqc_pkg::OP_Q2E) ? s.ly[l][eqc_pkg::LANE_W-1]
                                         : !s.lz[l][eqc_pkg::ANG_W-1];
          if (d) begin
            r.lx[l] = $signed(s.lx[l]) - dx;
            r.ly[l] = $signed(s.ly[l]) + dy;
            r.lz[l] = $signed(s.lz[l]) - atn;
          end else begin
            r.lx[l] = $signed(s.lx[l]) + dx;
            r.ly[l] = $signed(s.ly[l]) - dy;
            r.lz[l] = $signed(s.lz[l]) + atn;
          end
        end
      end else if (k == eqc_pkg::ST_MUL) begin
        if (s.op == eqc_pkg::OP_E2Q) begin
          for (int l = 0; l < 3; l++) begin
            cv[l] = s.lflag[l] ? -$signed(s.lx[l][33:0]) : $signed(s.lx[l][33:0]);
            sn[l] = s.lflag[l] ? -$signed(s.ly[l][33:0]) : $signed(s.ly[l][33:0]);
          end
          r.m[0]  = eqc_pkg::mulw(cv[0], cv[1]);
          r.m[1]  = eqc_pkg::mulw(sn[0], sn[1]);
          r.m[2]  = eqc_pkg::mulw(cv[0], sn[1]);
          r.m[3]  = eqc_pkg::mulw(sn[0], cv[1]);
          r.lx[2] = {{8{cv[2][33]}}, cv[2]};
          r.ly[2] = {{8{sn[2][33]}}, sn[2]};
        end else begin
          r.rr   = s.lflag[0] ? '0 : eqc_pkg::to_angle(s.lz[0]);
          r.rp   = s.lflag[1] ? '0 : eqc_pkg::to_angle(s.lz[1]);
          r.ryaw = s.lflag[2] ? '0 : eqc_pkg::to_angle(s.lz[2]);
        end
      end else if (k == eqc_pkg::ST_FIN) begin
        if (s.op == eqc_pkg::OP_E2Q) begin
          acc  = 38'(eqc_pkg::mulw(s.m[0][33:0], s.lx[2][33:0]))
               + 38'(eqc_pkg::mulw(s.m[1][33:0], s.ly[2][33:0]));
          r.rw = eqc_pkg::sat32(acc);
          acc  = 38'(eqc_pkg::mulw(s.m[3][33:0], s.lx[2][33:0]))
               - 38'(eqc_pkg::mulw(s.m[2][33:0], s.ly[2][33:0]));
          r.rx = eqc_pkg::sat32(acc);
          acc  = 38'(eqc_pkg::mulw(s.m[2][33:0], s.lx[2][33:0]))
               + 38'(eqc_pkg::mulw(s.m[3][33:0], s.ly[2][33:0]));
          r.ry = eqc_pkg::sat32(acc);
          acc  = 38'(eqc_pkg::mulw(s.m[0][33:0], s.ly[2][33:0]))
               - 38'(eqc_pkg::mulw(s.m[1][33:0], s.lx[2][33:0]));
          r.rz = eqc_pkg::sat32(acc);
        end
      end
      return r;
    end
  endfunction

  assign adv[NS]    = out_ready_i;
  assign in_ready_o = adv[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    assign adv[k] = !vld_q[k] || adv[k+1];

    if (k == 0) begin : g_first
      always_comb begin
        pipe_d[0]       = '0;
        pipe_d[0].op    = opcode_i;
        pipe_d[0].stamp = stamp_i;
        pipe_d[0].roll  = roll_angle_i;
        pipe_d[0].pitch = pitch_angle_i;
        pipe_d[0].yaw   = yaw_angle_i;
        pipe_d[0].qw    = quat_w_i;
        pipe_d[0].qx    = quat_x_i;
        pipe_d[0].qy    = quat_y_i;
        pipe_d[0].qz    = quat_z_i;
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[0] <= 1'b0;
        end else if (adv[0]) begin
          vld_q[0] <= in_valid_i;
        end
      end
    end else begin : g_next
      always_comb begin
        pipe_d[k] = step(k, pipe_q[k-1]);
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign out_valid_o    = vld_q[NS-1];
  assign stamp_out_o    = pipe_q[NS-1].stamp;
  assign asin_clamped_o = pipe_q[NS-1].clamp;

  always_comb begin
    if (pipe_q[NS-1].op == eqc_pkg::OP_Q2E) begin
      out_roll_o  = pipe_q[NS-1].rr;
      out_pitch_o = pipe_q[NS-1].rp;
      out_yaw_o   = pipe_q[NS-1].ryaw;
      out_w_o     = pipe_q[NS-1].qw;
      out_x_o     = pipe_q[NS-1].qx;
      out_y_o     = pipe_q[NS-1].qy;
      out_z_o     = pipe_q[NS-1].qz;
    end else begin
      out_roll_o  = pipe_q[NS-1].roll;
      out_pitch_o = pipe_q[NS-1].pitch;
      out_yaw_o   = pipe_q[NS-1].yaw;
      out_w_o     = pipe_q[NS-1].rw;
      out_x_o     = pipe_q[NS-1].rx;
      out_y_o     = pipe_q[NS-1].ry;
      out_z_o     = pipe_q[NS-1].rz;
    end
  end

endmodule

// File: rtl/eqc_checker.sv
// Port-level checker for the Euler/quaternion converter, with its bind statement.
// Depends on eqc_pkg for the pipeline depth.
module eqc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [63:0] stamp_out_i,
  input logic signed [30:0] out_pitch_i,
  input logic signed [31:0] out_w_i,
  input logic               asin_clamped_i
);

  localparam int CW = $clog2(eqc_pkg::NUM_STAGES + 1);

  logic [CW-1:0] cnt_q;
  logic [CW-1:0] cnt_d;
  logic          in_beat;
  logic          out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_beat && !out_beat) cnt_d = cnt_q + CW'(1);
    if (!in_beat && out_beat) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(stamp_out_i)
      && $stable(out_w_i) && $stable(out_pitch_i))
    else $error("result beat changed while stalled");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result beat without an outstanding input beat");

  a_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(eqc_pkg::NUM_STAGES))
    else $error("more beats in flight than pipeline stages");

  a_clamp_pitch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && asin_clamped_i |->
      (out_pitch_i > 31'sd400000000) || (out_pitch_i < -31'sd400000000))
    else $error("saturated asin argument without a pitch near a right angle");

endmodule

bind euler_quaternion_convert_top eqc_checker u_eqc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .stamp_out_i    (stamp_out_o),
  .out_pitch_i    (out_pitch_o),
  .out_w_i        (out_w_o),
  .asin_clamped_i (asin_clamped_o)
);
